>>> design/fcca_pkg.sv
// ----------------------------------------------------------------------------
// fcca_pkg
// shared types, codes and constants of the fat12 cluster chain allocator
// ----------------------------------------------------------------------------
package fcca_pkg;

	localparam int OP_W              = 3;
	localparam int ENTRY_W           = 12;
	localparam int TABLE_ENTRIES_DEF = 4096;

	localparam logic [ENTRY_W-1:0] END_OF_CHAIN       = 12'hFFF;
	localparam logic [ENTRY_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
	localparam logic [ENTRY_W-1:0] HIGHEST_RESET      = 12'd2848;

	// operation codes of the request channel
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 3'd0,
		OP_READ  = 3'd1,
		OP_BEGIN = 3'd2,
		OP_ALLOC = 3'd3,
		OP_COUNT = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_READ_WAIT,
		ST_ALLOC_SCAN,
		ST_COUNT_SCAN,
		ST_LINK,
		ST_MARK,
		ST_DONE
	} state_t;

	// table write port source
	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_LOAD,
		WR_LINK,
		WR_MARK
	} wr_sel_t;

	// result register source
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_READ,
		RES_CLUS,
		RES_COUNT,
		RES_FULL
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     tail_clr;
		logic     tail_set;
		logic     scan_en;
		logic     rd_scan;
		wr_sel_t  wr_sel;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_hit;
		logic scan_done;
	} dp_sts_t;

endpackage

>>> design/fcca_intf.sv
// ----------------------------------------------------------------------------
// fcca channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fcca_req_if;
	logic                          valid;
	logic                          ready;
	logic [fcca_pkg::OP_W-1:0]     operation;
	logic [fcca_pkg::ENTRY_W-1:0]  entry_index;
	logic [fcca_pkg::ENTRY_W-1:0]  entry_value;

	modport source(output valid, operation, entry_index, entry_value, input ready);
	modport sink(input valid, operation, entry_index, entry_value, output ready);
endinterface

interface fcca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fcca_pkg::ENTRY_W-1:0]  result_value;
	logic                          status;

	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

>>> design/fcca_dp.sv
// ----------------------------------------------------------------------------
// fcca_dp
// datapath: fat table memory, scan counter, chain tail, result registers
// ----------------------------------------------------------------------------
module fcca_dp #(
	parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fcca_pkg::dp_cmd_t             cmd,
	output fcca_pkg::dp_sts_t             sts,
	input  logic [fcca_pkg::ENTRY_W-1:0]  entry_index,
	input  logic [fcca_pkg::ENTRY_W-1:0]  entry_value,
	input  logic                          cfg_we,
	input  logic [fcca_pkg::ENTRY_W-1:0]  cfg_wdata,
	output logic [fcca_pkg::ENTRY_W-1:0]  result_value,
	output logic                          status
);

	localparam int ENTRY_W = fcca_pkg::ENTRY_W;
	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int A_W     = IDX_W + 1;
	localparam logic [ENTRY_W:0] LAST_WIDE  = (ENTRY_W+1)'(TABLE_ENTRIES - 1);
	localparam logic [ENTRY_W:0] DEPTH_WIDE = (ENTRY_W+1)'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);

	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

	logic [ENTRY_W-1:0] highest_q;
	logic [ENTRY_W-1:0] idx_q;
	logic [ENTRY_W-1:0] val_q;
	logic               idx_ok_q;
	logic [IDX_W-1:0]   lim_q;
	logic [A_W-1:0]     scan_addr_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   cand_s1;
	logic [ENTRY_W-1:0] rdata_s1;
	logic [IDX_W-1:0]   clus_q;
	logic [IDX_W-1:0]   count_q;
	logic [IDX_W-1:0]   tail_q;
	logic [ENTRY_W-1:0] res_q;
	logic               stat_q;
	logic [ENTRY_W-1:0] out_value_q;
	logic               out_status_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [IDX_W-1:0]   rd_addr;
	logic               scan_more;
	logic               hit;

	assign scan_more = scan_addr_q <= {1'b0, lim_q};
	assign hit       = pend_s1 && (rdata_s1 == '0);

	assign sts.clear_last = scan_addr_q[IDX_W-1:0] == LAST_IDX;
	assign sts.scan_hit   = hit;
	assign sts.scan_done  = !pend_s1 && !scan_more;

	assign rd_addr = cmd.rd_scan ? scan_addr_q[IDX_W-1:0] : idx_q[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_addr_q[IDX_W-1:0];
		wr_data = '0;
		unique case (cmd.wr_sel)
			fcca_pkg::WR_CLEAR: begin
				wr_en = 1'b1;
			end
			fcca_pkg::WR_LOAD: begin
				wr_en   = idx_ok_q;
				wr_addr = idx_q[IDX_W-1:0];
				wr_data = val_q;
			end
			fcca_pkg::WR_LINK: begin
				// first cluster of a chain has no predecessor to link
				wr_en   = tail_q != '0;
				wr_addr = tail_q;
				wr_data = ENTRY_W'(clus_q);
			end
			fcca_pkg::WR_MARK: begin
				wr_en   = 1'b1;
				wr_addr = clus_q;
				wr_data = fcca_pkg::END_OF_CHAIN;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// table with one write port and one read port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q   <= fcca_pkg::HIGHEST_RESET;
			scan_addr_q <= '0;
			pend_s1     <= 1'b0;
			count_q     <= '0;
			tail_q      <= '0;
		end else begin
			if (cfg_we) begin
				highest_q <= cfg_wdata;
			end
			pend_s1 <= cmd.scan_en && scan_more;
			if (cmd.capture) begin
				scan_addr_q <= A_W'(fcca_pkg::FIRST_DATA_CLUSTER);
				count_q     <= '0;
			end else if (cmd.wr_sel == fcca_pkg::WR_CLEAR || (cmd.scan_en && scan_more)) begin
				scan_addr_q <= scan_addr_q + A_W'(1);
			end
			if (cmd.scan_en && hit) begin
				count_q <= count_q + IDX_W'(1);
			end
			if (cmd.tail_clr) begin
				tail_q <= '0;
			end else if (cmd.tail_set) begin
				tail_q <= clus_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q    <= entry_index;
			val_q    <= entry_value;
			idx_ok_q <= {1'b0, entry_index} < DEPTH_WIDE;
			lim_q    <= ({1'b0, highest_q} >= LAST_WIDE) ? LAST_IDX : highest_q[IDX_W-1:0];
		end
		if (cmd.scan_en && scan_more) begin
			cand_s1 <= scan_addr_q[IDX_W-1:0];
		end
		// only a hit seen while scanning picks the cluster; the read in flight
		// when the scan stops must not replace it
		if (cmd.scan_en && hit) begin
			clus_q <= cand_s1;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				fcca_pkg::RES_READ: begin
					res_q  <= idx_ok_q ? rdata_s1 : '0;
					stat_q <= 1'b0;
				end
				fcca_pkg::RES_CLUS: begin
					res_q  <= ENTRY_W'(clus_q);
					stat_q <= 1'b0;
				end
				fcca_pkg::RES_COUNT: begin
					res_q  <= ENTRY_W'(count_q);
					stat_q <= 1'b0;
				end
				fcca_pkg::RES_FULL: begin
					res_q  <= '0;
					stat_q <= 1'b1;
				end
				default: begin
					res_q  <= '0;
					stat_q <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_value_q  <= res_q;
			out_status_q <= stat_q;
		end
	end

	assign result_value = out_value_q;
	assign status       = out_status_q;

endmodule

>>> design/fcca_ctrl.sv
// ----------------------------------------------------------------------------
// fcca_ctrl
// controller: sequences clear pass, table access, scans and result hand-off
// ----------------------------------------------------------------------------
module fcca_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [fcca_pkg::OP_W-1:0]  req_operation,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output fcca_pkg::dp_cmd_t          cmd,
	input  fcca_pkg::dp_sts_t          sts
);

	fcca_pkg::state_t state_q;
	fcca_pkg::state_t state_d;
	logic             out_valid_q;
	logic             accept;

	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcca_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd          = '0;
		cmd.wr_sel   = fcca_pkg::WR_NONE;
		cmd.res_sel  = fcca_pkg::RES_ZERO;
		unique case (state_q)
			fcca_pkg::ST_CLEAR: begin
				cmd.wr_sel = fcca_pkg::WR_CLEAR;
				if (sts.clear_last) begin
					state_d = fcca_pkg::ST_IDLE;
				end
			end
			fcca_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (fcca_pkg::op_t'(req_operation))
						fcca_pkg::OP_LOAD:  state_d = fcca_pkg::ST_LOAD;
						fcca_pkg::OP_READ:  state_d = fcca_pkg::ST_READ;
						fcca_pkg::OP_ALLOC: state_d = fcca_pkg::ST_ALLOC_SCAN;
						fcca_pkg::OP_COUNT: state_d = fcca_pkg::ST_COUNT_SCAN;
						fcca_pkg::OP_BEGIN: begin
							cmd.tail_clr = 1'b1;
							cmd.res_load = 1'b1;
							state_d      = fcca_pkg::ST_DONE;
						end
						default: begin
							cmd.res_load = 1'b1;
							state_d      = fcca_pkg::ST_DONE;
						end
					endcase
				end
			end
			fcca_pkg::ST_LOAD: begin
				cmd.wr_sel   = fcca_pkg::WR_LOAD;
				cmd.res_load = 1'b1;
				state_d      = fcca_pkg::ST_DONE;
			end
			fcca_pkg::ST_READ: begin
				state_d = fcca_pkg::ST_READ_WAIT;
			end
			fcca_pkg::ST_READ_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = fcca_pkg::RES_READ;
				state_d      = fcca_pkg::ST_DONE;
			end
			fcca_pkg::ST_ALLOC_SCAN: begin
				cmd.scan_en = 1'b1;
				cmd.rd_scan = 1'b1;
				if (sts.scan_hit) begin
					state_d = fcca_pkg::ST_LINK;
				end else if (sts.scan_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = fcca_pkg::RES_FULL;
					state_d      = fcca_pkg::ST_DONE;
				end
			end
			fcca_pkg::ST_COUNT_SCAN: begin
				cmd.scan_en = 1'b1;
				cmd.rd_scan = 1'b1;
				if (sts.scan_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = fcca_pkg::RES_COUNT;
					state_d      = fcca_pkg::ST_DONE;
				end
			end
			fcca_pkg::ST_LINK: begin
				cmd.wr_sel = fcca_pkg::WR_LINK;
				state_d    = fcca_pkg::ST_MARK;
			end
			fcca_pkg::ST_MARK: begin
				// end mark after the link so a reused tail ends as end-of-chain
				cmd.wr_sel   = fcca_pkg::WR_MARK;
				cmd.tail_set = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_sel  = fcca_pkg::RES_CLUS;
				state_d      = fcca_pkg::ST_DONE;
			end
			fcca_pkg::ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = fcca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcca_pkg::ST_IDLE;
			end
		endcase
	end

	// one item in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request accepted while an item is still in flight");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("result register overwritten before it was taken");

	// end mark always follows the link write
	a_link_before_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_sel == fcca_pkg::WR_MARK |-> $past(cmd.wr_sel) == fcca_pkg::WR_LINK)
		else $error("end-of-chain mark not preceded by link write");

	// no item is taken before the clearing pass is over
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_sel == fcca_pkg::WR_CLEAR |=> !sts.scan_hit && !$past(accept))
		else $error("request taken during table clearing pass");

endmodule

>>> design/fat12_cluster_chain_allocator_core.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_allocator_core
// fat12 cluster table with chain allocation, entry access and free count
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one beat per operation: operation,
//   entry_index, entry_value. rsp channel returns exactly one beat per request
//   with result_value and status (status high only when allocate finds no
//   free cluster). cfg_we/cfg_wdata write highest_cluster; write it only while
//   the block holds no request whose response is still outstanding.
// sequencing, from the request beat to the response register
//   load writes the entry when its index is in range; read reads it from the
//   table; begin chain clears the chain tail. allocate scans from cluster 2
//   for the first free entry, links the tail to it and marks it end of chain.
//   count free scans from cluster 2 to the scan limit. the scans read the
//   single table read port one entry per cycle; one request is worked on at
//   a time
// reset
//   arst_n clears control state and starts a clearing pass that writes zero
//   to every table entry; req.ready stays low until it completes. highest_cluster
//   resets to 2848, chain tail to zero
// stall
//   a finished response waits in the output register while rsp.ready is low;
//   the next request is accepted meanwhile and held at completion until the
//   output register frees up
// ----------------------------------------------------------------------------
module fat12_cluster_chain_allocator_core #(
	parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fcca_req_if.sink                      req,
	fcca_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [fcca_pkg::ENTRY_W-1:0]  cfg_wdata
);

	// command and status between sequencer and datapath
	fcca_pkg::dp_cmd_t cmd;
	fcca_pkg::dp_sts_t sts;

	// controller: clear pass, per-operation sequencing, response handshake
	fcca_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.req_operation (req.operation),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	// datapath: table memory, scan pipeline, tail and response payload
	fcca_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (req.entry_index),
		.entry_value  (req.entry_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_value (rsp.result_value),
		.status       (rsp.status)
	);

endmodule
